// File: rtl/core/slrc_pkg.sv
// ----------------------------------------------------------------------------
// slrc_pkg: shared types and constants
// Request formats, divider request and controller states.
// ----------------------------------------------------------------------------
package slrc_pkg;

	localparam int LAT_W   = 32;
	localparam int PCT_W   = 7;
	localparam int ACC_L_W = 44;
	localparam int ACC_U_W = 19;
	localparam int WT_W    = 12;
	localparam int DVD_W   = 44;
	localparam int DVS_W   = 33;
	localparam int CNT_W   = 6;

	localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
	localparam logic [PCT_W-1:0]   MAX_PERIOD = 7'd64;
	localparam logic [3:0]         HIST_WT    = 4'd4;
	localparam logic [3:0]         CUR_WT     = 4'd6;
	localparam logic [ACC_L_W-1:0] ACC_L_MAX  = {ACC_L_W{1'b1}};
	localparam logic [ACC_U_W-1:0] ACC_U_MAX  = {ACC_U_W{1'b1}};
	localparam logic [WT_W-1:0]    WT_MAX     = {WT_W{1'b1}};

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_STATIC = 3'd1;
	localparam logic [2:0] REG_STEP   = 3'd2;
	localparam logic [2:0] REG_FBUSY  = 3'd3;
	localparam logic [2:0] REG_NBUSY  = 3'd4;
	localparam logic [2:0] REG_GAP    = 3'd5;
	localparam logic [2:0] REG_PERIOD = 3'd6;

	localparam logic [1:0] MODE_LATENCY = 2'd0;
	localparam logic [1:0] MODE_THRUPUT = 2'd1;

	typedef struct packed {
		logic [LAT_W-1:0] fast_latency;
		logic [LAT_W-1:0] normal_latency;
		logic [PCT_W-1:0] fast_utilization;
		logic [PCT_W-1:0] normal_utilization;
	} in_req_t;

	typedef struct packed {
		logic [PCT_W-1:0] route_ratio;
		logic             period_done;
		logic [LAT_W-1:0] smooth_fast_latency;
		logic [LAT_W-1:0] smooth_normal_latency;
	} out_req_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_ACC,
		ST_AVG,
		ST_BLEND,
		ST_ADJ,
		ST_GAP,
		ST_OUT
	} state_t;

endpackage

// File: rtl/core/slrc_div.sv
// ----------------------------------------------------------------------------
// slrc_div: bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
module slrc_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  slrc_pkg::div_req_t      req,
	output logic                    done,
	output logic [slrc_pkg::DVD_W-1:0] quot,
	output logic [slrc_pkg::DVS_W-1:0] rem
);
	import slrc_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W:0]   diff;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

// File: rtl/core/smoothed_load_ratio_controller.sv
// ----------------------------------------------------------------------------
// smoothed_load_ratio_controller: smoothed fast/normal routing ratio
// Accumulates weighted tick samples and adjusts a 0..100 routing ratio.
// ----------------------------------------------------------------------------
// Each tick takes one divider pass for the phase; a period end adds eight more
// passes for averages and blends, and one more when the latency gap is tested.
// One request at a time: the next is accepted once the result is registered at
// the output, which waits while an earlier output is still stalled.
// Reset clears config to defaults and all phase, sums, history and ratio.
module smoothed_load_ratio_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [2:0]                    cfg_index,
	input  logic [slrc_pkg::PCT_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  slrc_pkg::in_req_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output slrc_pkg::out_req_t            out_data
);
	import slrc_pkg::*;

	logic [1:0]       mode_q;
	logic [PCT_W-1:0] static_q, step_q, fbusy_q, nbusy_q, gap_q, period_cfg_q;

	state_t state_q, state_d;
	logic   go_q;

	logic [LAT_W-1:0]   fl_q, nl_q;
	logic [PCT_W-1:0]   fu_q, nu_q;
	logic [5:0]         phase_q;
	logic [ACC_L_W-1:0] acc_fl_q, acc_nl_q;
	logic [ACC_U_W-1:0] acc_fu_q, acc_nu_q;
	logic [WT_W-1:0]    wt_q;
	logic [LAT_W-1:0]   hist_fl_q, hist_nl_q;
	logic [PCT_W-1:0]   hist_fu_q, hist_nu_q;
	logic [PCT_W-1:0]   ratio_q;
	logic [LAT_W-1:0]   cur_q;
	logic [1:0]         k_q;
	logic               done_q;
	logic               out_valid_q;
	out_req_t           out_q;

	div_req_t          dreq;
	logic              ddone;
	logic [DVD_W-1:0]  dquot;
	logic [DVS_W-1:0]  drem;

	logic [PCT_W-1:0]   period;
	logic [PCT_W-1:0]   rem7;
	logic [PCT_W-1:0]   weight;
	logic [ACC_L_W:0]   sum_fl, sum_nl;
	logic [ACC_U_W:0]   sum_fu, sum_nu;
	logic [WT_W:0]      sum_wt;
	logic [ACC_L_W-1:0] acc_sel;
	logic [LAT_W-1:0]   old_sel;
	logic [LAT_W-1:0]   cur_clip;
	logic [LAT_W-1:0]   lat_hi, lat_lo;
	logic [LAT_W-1:0]   lat_diff;
	logic               out_free;
	logic               latency_go;

	function automatic logic [PCT_W-1:0] raise(input logic [PCT_W-1:0] r,
		input logic [PCT_W-1:0] s);
		logic [PCT_W-1:0] room;
		room = PCT_MAX - r;
		return r + ((s < room) ? s : room);
	endfunction

	function automatic logic [PCT_W-1:0] lower(input logic [PCT_W-1:0] r,
		input logic [PCT_W-1:0] s);
		return r - ((s < r) ? s : r);
	endfunction

	slrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.quot   (dquot),
		.rem    (drem)
	);

	always_comb begin
		if (period_cfg_q == '0)
			period = PCT_W'(1);
		else if (period_cfg_q > MAX_PERIOD)
			period = MAX_PERIOD;
		else
			period = period_cfg_q;
	end

	assign rem7   = drem[PCT_W-1:0];
	assign weight = (rem7 == '0) ? period : rem7;
	assign sum_fl = {1'b0, acc_fl_q} + (ACC_L_W+1)'(weight * fl_q);
	assign sum_nl = {1'b0, acc_nl_q} + (ACC_L_W+1)'(weight * nl_q);
	assign sum_fu = {1'b0, acc_fu_q} + (ACC_U_W+1)'(weight * fu_q);
	assign sum_nu = {1'b0, acc_nu_q} + (ACC_U_W+1)'(weight * nu_q);
	assign sum_wt = {1'b0, wt_q} + (WT_W+1)'(weight);

	always_comb begin
		case (k_q)
			2'd0: begin acc_sel = acc_fl_q; old_sel = hist_fl_q; end
			2'd1: begin acc_sel = acc_nl_q; old_sel = hist_nl_q; end
			2'd2: begin
				acc_sel = ACC_L_W'(acc_fu_q);
				old_sel = LAT_W'(hist_fu_q);
			end
			default: begin
				acc_sel = ACC_L_W'(acc_nu_q);
				old_sel = LAT_W'(hist_nu_q);
			end
		endcase
	end

	always_comb begin
		if (!k_q[1])
			cur_clip = (dquot > DVD_W'({LAT_W{1'b1}})) ? {LAT_W{1'b1}} : dquot[LAT_W-1:0];
		else
			cur_clip = (dquot > DVD_W'(PCT_MAX)) ? LAT_W'(PCT_MAX) : dquot[LAT_W-1:0];
	end

	assign lat_hi     = (hist_nl_q > hist_fl_q) ? hist_nl_q : hist_fl_q;
	assign lat_lo     = (hist_nl_q > hist_fl_q) ? hist_fl_q : hist_nl_q;
	assign lat_diff   = lat_hi - lat_lo;
	assign out_free   = !out_valid_q || !out_stall;
	assign latency_go = (static_q == '0) && (mode_q == MODE_LATENCY)
		&& (hist_fl_q != hist_nl_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MOD;
			ST_MOD:   if (ddone) state_d = ST_ACC;
			ST_ACC:   state_d = done_q ? ST_AVG : ST_OUT;
			ST_AVG:   if (ddone) state_d = ST_BLEND;
			ST_BLEND: if (ddone) state_d = (k_q == 2'd3) ? ST_ADJ : ST_AVG;
			ST_ADJ:   state_d = latency_go ? ST_GAP : ST_OUT;
			ST_GAP:   if (ddone) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		dreq.start    = go_q;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		in_stall      = 1'b1;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_MOD: begin
				dreq.dividend = DVD_W'(phase_q);
				dreq.divisor  = DVS_W'(period);
			end
			ST_AVG: begin
				dreq.dividend = acc_sel;
				dreq.divisor  = DVS_W'(wt_q);
			end
			ST_BLEND: begin
				dreq.dividend = DVD_W'(old_sel) * DVD_W'(HIST_WT)
					+ DVD_W'(cur_q) * DVD_W'(CUR_WT);
				dreq.divisor  = DVS_W'(HIST_WT) + DVS_W'(CUR_WT);
			end
			ST_GAP: begin
				dreq.dividend = DVD_W'(lat_diff) * DVD_W'(PCT_MAX);
				dreq.divisor  = DVS_W'(lat_hi);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			go_q         <= 1'b0;
			mode_q       <= MODE_THRUPUT;
			static_q     <= '0;
			step_q       <= PCT_W'(10);
			fbusy_q      <= PCT_W'(70);
			nbusy_q      <= PCT_W'(70);
			gap_q        <= PCT_W'(15);
			period_cfg_q <= PCT_W'(1);
			phase_q      <= '0;
			acc_fl_q     <= '0;
			acc_nl_q     <= '0;
			acc_fu_q     <= '0;
			acc_nu_q     <= '0;
			wt_q         <= '0;
			hist_fl_q    <= '0;
			hist_nl_q    <= '0;
			hist_fu_q    <= '0;
			hist_nu_q    <= '0;
			ratio_q      <= '0;
			k_q          <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= (state_d != state_q) && (state_d == ST_MOD || state_d == ST_AVG
				|| state_d == ST_BLEND || state_d == ST_GAP);
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_MODE:   mode_q       <= cfg_data[1:0];
					REG_STATIC: static_q     <= cfg_data;
					REG_STEP:   step_q       <= cfg_data;
					REG_FBUSY:  fbusy_q      <= cfg_data;
					REG_NBUSY:  nbusy_q      <= cfg_data;
					REG_GAP:    gap_q        <= cfg_data;
					REG_PERIOD: period_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_MOD: if (ddone) begin
					done_q  <= weight == period;
					phase_q <= (rem7 + 1'b1 == period) ? '0 : 6'(rem7 + 1'b1);
					acc_fl_q <= sum_fl[ACC_L_W] ? ACC_L_MAX : sum_fl[ACC_L_W-1:0];
					acc_nl_q <= sum_nl[ACC_L_W] ? ACC_L_MAX : sum_nl[ACC_L_W-1:0];
					acc_fu_q <= sum_fu[ACC_U_W] ? ACC_U_MAX : sum_fu[ACC_U_W-1:0];
					acc_nu_q <= sum_nu[ACC_U_W] ? ACC_U_MAX : sum_nu[ACC_U_W-1:0];
					wt_q     <= sum_wt[WT_W] ? WT_MAX : sum_wt[WT_W-1:0];
				end
				ST_ACC: k_q <= '0;
				ST_AVG: if (ddone) cur_q <= cur_clip;
				ST_BLEND: if (ddone) begin
					case (k_q)
						2'd0: hist_fl_q <= dquot[LAT_W-1:0];
						2'd1: hist_nl_q <= dquot[LAT_W-1:0];
						2'd2: hist_fu_q <= dquot[PCT_W-1:0];
						default: hist_nu_q <= dquot[PCT_W-1:0];
					endcase
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						acc_fl_q <= '0;
						acc_nl_q <= '0;
						acc_fu_q <= '0;
						acc_nu_q <= '0;
						wt_q     <= '0;
					end
				end
				ST_ADJ: begin
					if (static_q != '0)
						ratio_q <= (static_q > PCT_MAX) ? PCT_MAX : static_q;
					else if (mode_q == MODE_THRUPUT) begin
						if (hist_fu_q < fbusy_q)
							ratio_q <= raise(ratio_q, step_q);
						else if (hist_nu_q < nbusy_q)
							ratio_q <= lower(ratio_q, step_q);
					end
				end
				ST_GAP: if (ddone && dquot > DVD_W'(gap_q)) begin
					if (hist_nl_q > hist_fl_q)
						ratio_q <= raise(ratio_q, step_q);
					else
						ratio_q <= lower(ratio_q, step_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			fl_q <= in_data.fast_latency;
			nl_q <= in_data.normal_latency;
			fu_q <= (in_data.fast_utilization > PCT_MAX) ? PCT_MAX
				: in_data.fast_utilization;
			nu_q <= (in_data.normal_utilization > PCT_MAX) ? PCT_MAX
				: in_data.normal_utilization;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.route_ratio           <= ratio_q;
			out_q.period_done           <= done_q;
			out_q.smooth_fast_latency   <= hist_fl_q;
			out_q.smooth_normal_latency <= hist_nl_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: tb/sv/smoothed_load_ratio_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smoothed_load_ratio_controller_tb: self-checking testbench
// Drives sample ticks through the valid/stall request channel, predicts the
// smoothed latencies and routing ratio per tick, and checks every output
// request in order. A directed table precedes randomized configuration phases
// with random gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module smoothed_load_ratio_controller_tb;
	import slrc_pkg::*;

	localparam logic [1:0] MODE_HOLD  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [63:0] LAT_CAP = 64'hFFFF_FFFF;

	typedef struct {
		out_req_t  pred;
		bit        typed;
		logic [6:0] ratio;
		logic       done;
	} tick_exp_t;

	typedef struct {
		bit         is_cfg;
		logic [2:0] idx;
		logic [6:0] val;
		in_req_t    d;
		bit         typed;
		logic [6:0] ratio;
		logic       done;
	} row_t;

	logic clk, arst_n, cfg_wen, in_valid, in_stall, out_valid, out_stall;
	logic [2:0] cfg_index;
	logic [6:0] cfg_data;
	in_req_t in_data;
	out_req_t out_data;

	logic [1:0] m_mode;
	logic [6:0] m_static, m_step, m_fbusy, m_nbusy, m_gap, m_period;
	logic [63:0] s_phase, a_fl, a_nl, a_fu, a_nu, a_wt, h_fl, h_nl, h_fu, h_nu, s_ratio;

	tick_exp_t tick_q[$];
	row_t rows[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	bit hold_request = 0;

	smoothed_load_ratio_controller dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] sat(logic [63:0] s, logic [63:0] cap);
		return (s > cap) ? cap : s;
	endfunction

	function automatic logic [63:0] blend(logic [63:0] old, logic [63:0] acc,
			logic [63:0] cap);
		logic [63:0] cur;
		cur = acc / a_wt;
		if (cur > cap)
			cur = cap;
		return (old * 4 + cur * 6) / 10;
	endfunction

	function automatic void ratio_step(bit up);
		logic [63:0] room;
		room = up ? (100 - s_ratio) : s_ratio;
		if (up)
			s_ratio += (m_step < room) ? m_step : room;
		else
			s_ratio -= (m_step < room) ? m_step : room;
	endfunction

	function automatic out_req_t predict_tick(in_req_t t);
		logic [63:0] fl, nl, fu, nu, per, rem, wt;
		out_req_t r;
		fl = t.fast_latency;
		nl = t.normal_latency;
		fu = (t.fast_utilization > 100) ? 100 : t.fast_utilization;
		nu = (t.normal_utilization > 100) ? 100 : t.normal_utilization;
		per = (m_period == 0) ? 1 : ((m_period > 64) ? 64 : m_period);
		rem = s_phase % per;
		wt = (rem == 0) ? per : rem;
		s_phase = (rem + 1 == per) ? 0 : ((rem + 1) & 63);
		a_fl = sat(a_fl + wt * fl, ACC_L_MAX);
		a_nl = sat(a_nl + wt * nl, ACC_L_MAX);
		a_fu = sat(a_fu + wt * fu, ACC_U_MAX);
		a_nu = sat(a_nu + wt * nu, ACC_U_MAX);
		a_wt = sat(a_wt + wt, WT_MAX);
		r.period_done = (wt == per);
		if (r.period_done) begin
			h_fl = blend(h_fl, a_fl, LAT_CAP);
			h_nl = blend(h_nl, a_nl, LAT_CAP);
			h_fu = blend(h_fu, a_fu, 100);
			h_nu = blend(h_nu, a_nu, 100);
			a_fl = 0; a_nl = 0; a_fu = 0; a_nu = 0; a_wt = 0;
			if (m_static != 0) begin
				s_ratio = (m_static > 100) ? 100 : m_static;
			end else if (m_mode == MODE_LATENCY) begin
				if (h_nl > h_fl) begin
					if ((h_nl - h_fl) * 100 / h_nl > m_gap)
						ratio_step(1);
				end else if (h_fl > h_nl) begin
					if ((h_fl - h_nl) * 100 / h_fl > m_gap)
						ratio_step(0);
				end
			end else if (m_mode == MODE_THRUPUT) begin
				if (h_fu < m_fbusy)
					ratio_step(1);
				else if (h_nu < m_nbusy)
					ratio_step(0);
			end
		end
		r.route_ratio = s_ratio[6:0];
		r.smooth_fast_latency = h_fl[31:0];
		r.smooth_normal_latency = h_nl[31:0];
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 200);
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (tick_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [6:0] val);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_MODE:   m_mode = val[1:0];
			REG_STATIC: m_static = val;
			REG_STEP:   m_step = val;
			REG_FBUSY:  m_fbusy = val;
			REG_NBUSY:  m_nbusy = val;
			REG_GAP:    m_gap = val;
			REG_PERIOD: m_period = val;
			default: ;
		endcase
	endtask

	task automatic send_tick(in_req_t d, bit typed, logic [6:0] ratio, logic done);
		tick_exp_t e;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = d;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		e.pred = predict_tick(d);
		e.typed = typed;
		e.ratio = ratio;
		e.done = done;
		tick_q.push_back(e);
		@(negedge clk);
	endtask

	function automatic in_req_t mk(logic [31:0] fl, logic [31:0] nl,
			logic [6:0] fu, logic [6:0] nu);
		in_req_t d;
		d.fast_latency = fl;
		d.normal_latency = nl;
		d.fast_utilization = fu;
		d.normal_utilization = nu;
		return d;
	endfunction

	function automatic void add_tick(in_req_t d, bit typed = 0, logic [6:0] r = 0,
			logic dn = 0);
		row_t w;
		w.is_cfg = 0;
		w.d = d;
		w.typed = typed;
		w.ratio = r;
		w.done = dn;
		rows.push_back(w);
	endfunction

	function automatic void add_cfg(logic [2:0] idx, logic [6:0] val);
		row_t w;
		w.is_cfg = 1;
		w.idx = idx;
		w.val = val;
		w.typed = 0;
		rows.push_back(w);
	endfunction

	function automatic logic [31:0] rand_lat();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1000);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			3: return $urandom_range(0, 3);
			default: return $urandom_range(0, 100000);
		endcase
	endfunction

	function automatic logic [6:0] rand_pct();
		return ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
			: 7'($urandom_range(0, 100));
	endfunction

	function automatic logic [6:0] rand_reg();
		case ($urandom_range(0, 5))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'($urandom_range(0, 127));
			default: return 7'($urandom_range(0, 40));
		endcase
	endfunction

	always @(negedge clk) begin
		static int run = 0;
		static int held = 0;
		if (hold_request && held == 0) begin
			held = HOLD_CYCLES;
			hold_request = 0;
		end
		if (held > 0) begin
			out_stall = 1'b1;
			held--;
		end else if (run > 0) begin
			out_stall = 1'b1;
			run--;
		end else if (quiet || $urandom_range(0, 9) < 7) begin
			out_stall = 1'b0;
		end else begin
			out_stall = 1'b1;
			run = gap_len();
		end
	end

	always @(posedge clk) begin
		tick_exp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tick_q.size() == 0) begin
				$display("mismatch: output request with none expected");
				errors++;
			end else begin
				e = tick_q.pop_front();
				if (out_data.route_ratio !== e.pred.route_ratio)
					report("route_ratio", out_data.route_ratio, e.pred.route_ratio);
				if (out_data.period_done !== e.pred.period_done)
					report("period_done", out_data.period_done, e.pred.period_done);
				if (out_data.smooth_fast_latency !== e.pred.smooth_fast_latency)
					report("smooth_fast_latency", out_data.smooth_fast_latency,
						e.pred.smooth_fast_latency);
				if (out_data.smooth_normal_latency !== e.pred.smooth_normal_latency)
					report("smooth_normal_latency", out_data.smooth_normal_latency,
						e.pred.smooth_normal_latency);
				if (e.typed && out_data.route_ratio !== e.ratio)
					report("route_ratio vs table", out_data.route_ratio, e.ratio);
				if (e.typed && out_data.period_done !== e.done)
					report("period_done vs table", out_data.period_done, e.done);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		in_req_t d;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		m_mode = MODE_THRUPUT; m_static = 0; m_step = 10; m_fbusy = 70; m_nbusy = 70;
		m_gap = 15; m_period = 1;
		s_phase = 0; a_fl = 0; a_nl = 0; a_fu = 0; a_nu = 0; a_wt = 0;
		h_fl = 0; h_nl = 0; h_fu = 0; h_nu = 0; s_ratio = 0;

		add_tick(mk(0, 0, 0, 0), 1, 7'd10, 1);
		add_tick(mk('1, '1, 7'd127, 7'd127), 1, 7'd20, 1);
		add_cfg(REG_STATIC, 7'd100);
		add_tick(mk(32'd5, 32'd7, 7'd127, 7'd127), 1, 7'd100, 1);
		add_cfg(REG_STATIC, 7'd127);
		add_tick(mk(32'd1, '1, 7'd100, 7'd0), 1, 7'd100, 1);
		add_cfg(REG_STATIC, 7'd0);
		add_cfg(REG_STEP, 7'd100);
		add_cfg(REG_FBUSY, 7'd0);
		add_cfg(REG_NBUSY, 7'd100);
		add_tick(mk(32'd3, 32'd3, 7'd100, 7'd0), 1, 7'd0, 1);
		add_cfg(REG_FBUSY, 7'd100);
		add_tick(mk(32'd3, 32'd3, 7'd0, 7'd100), 1, 7'd100, 1);
		add_cfg(REG_MODE, 7'(MODE_LATENCY));
		add_cfg(REG_GAP, 7'd0);
		add_cfg(REG_STEP, 7'd0);
		add_tick(mk(32'd10, 32'd1000, 7'd50, 7'd50));
		add_cfg(REG_STEP, 7'd127);
		add_tick(mk(32'd0, 32'd0, 7'd50, 7'd50));
		add_tick(mk(32'd2000, 32'd10, 7'd50, 7'd50));
		add_cfg(REG_GAP, 7'd100);
		add_tick(mk(32'd10, '1, 7'd50, 7'd50));
		add_cfg(REG_MODE, 7'(MODE_HOLD));
		add_tick(mk('1, 32'd0, 7'd1, 7'd1));
		add_cfg(REG_MODE, 7'(MODE_SPARE));
		add_tick(mk(32'd0, '1, 7'd1, 7'd1));
		add_cfg(REG_PERIOD, 7'd0);
		add_tick(mk(32'h8000_0000, 32'h0000_0001, 7'd64, 7'd32), 1, 7'd100, 1);
		add_cfg(REG_PERIOD, 7'd127);
		add_tick(mk('1, '1, 7'd127, 7'd127), 1, 7'd100, 1);
		add_tick(mk('1, '1, 7'd127, 7'd127), 1, 7'd100, 0);
		add_cfg(REG_PERIOD, 7'd3);
		add_tick(mk(32'd7, 32'd9, 7'd3, 7'd4));
		add_tick(mk(32'd7, 32'd9, 7'd3, 7'd4));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_drained();
				write_reg(rows[i].idx, rows[i].val);
			end else begin
				send_tick(rows[i].d, rows[i].typed, rows[i].ratio, rows[i].done);
			end
		end

		for (int ph = 0; ph < 10; ph++) begin
			wait_drained();
			quiet = (ph % 4 == 1);
			write_reg(REG_MODE, 7'($urandom_range(0, 127)));
			write_reg(REG_STATIC, ($urandom_range(0, 9) < 7) ? 7'd0 : rand_reg());
			write_reg(REG_STEP, rand_reg());
			write_reg(REG_FBUSY, rand_reg());
			write_reg(REG_NBUSY, rand_reg());
			write_reg(REG_GAP, rand_reg());
			case ($urandom_range(0, 19))
				0, 1: write_reg(REG_PERIOD, 7'($urandom_range(65, 127)));
				2: write_reg(REG_PERIOD, 7'd0);
				3: write_reg(REG_PERIOD, 7'd64);
				4, 5, 6, 7, 8: write_reg(REG_PERIOD, 7'($urandom_range(7, 16)));
				default: write_reg(REG_PERIOD, 7'($urandom_range(1, 6)));
			endcase
			if (ph == 3)
				hold_request = 1;
			for (int k = 0; k < 110; k++) begin
				d.fast_latency = rand_lat();
				d.normal_latency = ($urandom_range(0, 7) == 0) ? d.fast_latency
					: rand_lat();
				d.fast_utilization = rand_pct();
				d.normal_utilization = rand_pct();
				send_tick(d, 0, 0, 0);
			end
		end

		wait_drained();
		repeat (600) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: smoothed_load_ratio_controller.f
rtl/core/slrc_pkg.sv
rtl/core/slrc_div.sv
rtl/core/smoothed_load_ratio_controller.sv
tb/sv/smoothed_load_ratio_controller_tb.sv
